@@ design/swrm_pkg.sv @@
package swrm_pkg;

  localparam int NODE_W      = 8;
  localparam int NODE_SPACE  = 2 ** NODE_W;
  localparam int SEQ_W       = 32;
  localparam int TIME_W      = 32;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int OP_W        = 3;
  localparam int DEST_W      = 9;
  localparam int ACT_W       = 4;
  localparam int KIND_W      = 2;
  localparam int RTO_W       = 16;
  localparam int ATT_W       = 8;

  localparam int MAX_NODES_DEF = 256;
  localparam int OUTQ_DEPTH    = 4;

  localparam logic [NODE_W-1:0] OWN_ID_RST        = 8'd0;
  localparam logic [ATT_W-1:0]  MAX_ATTEMPTS_RST  = 8'd3;
  localparam logic [RTO_W-1:0]  RETRY_TIMEOUT_RST = 16'd1000;

  typedef enum logic [OP_W-1:0] {
    OP_CHAT    = 3'd0,
    OP_CONFIRM = 3'd1,
    OP_OTHER   = 3'd2,
    OP_SEND    = 3'd3,
    OP_TICK    = 3'd4
  } op_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_FORWARD  = 4'd0,
    ACT_CONFIRM  = 4'd1,
    ACT_DELIVER  = 4'd2,
    ACT_CHAT     = 4'd3,
    ACT_SUCCESS  = 4'd4,
    ACT_FAILED   = 4'd5,
    ACT_BUSY     = 4'd6,
    ACT_REFUSED  = 4'd7,
    ACT_ACCEPTED = 4'd8
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAT    = 2'd0,
    KIND_CONFIRM = 2'd1,
    KIND_OTHER   = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ID        = 2'd0,
    CFG_MAX_ATTEMPTS  = 2'd1,
    CFG_RETRY_TIMEOUT = 2'd2,
    CFG_SLEEPING      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [NODE_W-1:0] own_id;
    logic [ATT_W-1:0]  max_attempts;
    logic [RTO_W-1:0]  retry_timeout;
    logic              sleeping;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [DEST_W-1:0] dest_node;
    logic [NODE_W-1:0]        source_node;
    logic [SEQ_W-1:0]         seq_number;
    logic [TIME_W-1:0]        now_ms;
  } item_t;

  typedef struct packed {
    action_t           action;
    kind_t             frame_kind;
    logic [NODE_W-1:0] target_node;
    logic [NODE_W-1:0] origin_node;
    logic [SEQ_W-1:0]  seq_out;
    logic              last;
  } res_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] node;
    logic [SEQ_W-1:0]  data;
  } mem_wr_t;

  typedef struct packed {
    logic              flag;
    logic [NODE_W-1:0] target_nxt;
  } pend_t;

endpackage

@@ design/stop_and_wait_reliable_messenger_top.sv @@
// Channel | Direction | Handshake             | Payload
// in_     | in        | in_valid / in_stall   | operation, dest_node, source_node,
//         |           |                       | seq_number, now_ms
// out_    | out       | out_valid / out_stall | action, frame_kind, target_node, origin_node,
//         |           |                       | seq_out, last
// cfg_    | in        | cfg_wr_en             | cfg_index, cfg_wdata
//
// One request is taken per cycle while in_stall is low; the sequence memories are read
// into registers at the accepting edge, decision and write-back follow when the held
// request fires, and its results then enter the queue. The output port, one result a
// cycle while out_stall is low, sets the sustained rate: a delivered chat yields two results.
// Reset (rst_n low, synchronous) clears the pending message, timers, result queue and
// memory valid bits. in_stall rises only while a request waits for queue room for two.
module stop_and_wait_reliable_messenger_top #(
  parameter int MAX_NODES = swrm_pkg::MAX_NODES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,

  input  logic                                  cfg_wr_en,
  input  logic [swrm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [swrm_pkg::CFG_DATA_W-1:0]       cfg_wdata,

  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [swrm_pkg::OP_W-1:0]             in_operation,
  input  logic signed [swrm_pkg::DEST_W-1:0]    in_dest_node,
  input  logic [swrm_pkg::NODE_W-1:0]           in_source_node,
  input  logic [swrm_pkg::SEQ_W-1:0]            in_seq_number,
  input  logic [swrm_pkg::TIME_W-1:0]           in_now_ms,

  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [swrm_pkg::ACT_W-1:0]            out_action,
  output logic [swrm_pkg::KIND_W-1:0]           out_frame_kind,
  output logic [swrm_pkg::NODE_W-1:0]           out_target_node,
  output logic [swrm_pkg::NODE_W-1:0]           out_origin_node,
  output logic [swrm_pkg::SEQ_W-1:0]            out_seq_out,
  output logic                                  out_last
);

  swrm_pkg::cfg_t     cfg_r;
  swrm_pkg::item_t    x_item_r;
  logic               x_vld_r, x_vld_nxt;
  logic               in_acc;
  logic               x_fire;
  logic               room;

  logic [swrm_pkg::SEQ_W-1:0]   exp_rd, cur_rd;
  logic [swrm_pkg::NODE_W-1:0]  cur_rd_node;
  swrm_pkg::mem_wr_t            exp_wr, cur_wr;
  swrm_pkg::res_t               res0, res1, head;
  logic [1:0]                   res_n;
  swrm_pkg::pend_t              pend;

  // Configuration: plain register writes; the user must issue them only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id        <= swrm_pkg::OWN_ID_RST;
      cfg_r.max_attempts  <= swrm_pkg::MAX_ATTEMPTS_RST;
      cfg_r.retry_timeout <= swrm_pkg::RETRY_TIMEOUT_RST;
      cfg_r.sleeping      <= 1'b0;
    end else if (cfg_wr_en) begin
      case (swrm_pkg::cfg_idx_t'(cfg_index))
        swrm_pkg::CFG_OWN_ID:        cfg_r.own_id        <= cfg_wdata[swrm_pkg::NODE_W-1:0];
        swrm_pkg::CFG_MAX_ATTEMPTS:  cfg_r.max_attempts  <= cfg_wdata[swrm_pkg::ATT_W-1:0];
        swrm_pkg::CFG_RETRY_TIMEOUT: cfg_r.retry_timeout <= cfg_wdata[swrm_pkg::RTO_W-1:0];
        swrm_pkg::CFG_SLEEPING:      cfg_r.sleeping      <= cfg_wdata[0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Decision stage fires when the queue can hold the worst case of two results;
  // hold the request otherwise.
  assign x_fire   = x_vld_r && room;
  assign in_stall = x_vld_r && !room;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    x_vld_nxt = x_vld_r;
    if (in_acc) begin
      x_vld_nxt = 1'b1;
    end else if (x_fire) begin
      x_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r <= 1'b0;
    end else begin
      x_vld_r <= x_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_item_r.operation   <= in_operation;
      x_item_r.dest_node   <= in_dest_node;
      x_item_r.source_node <= in_source_node;
      x_item_r.seq_number  <= in_seq_number;
      x_item_r.now_ms      <= in_now_ms;
    end
  end

  // Out-sequence address: the sender of a confirm, the target of a send, and
  // for a tick the pending target as the request now firing leaves it.
  always_comb begin
    case (swrm_pkg::op_t'(in_operation))
      swrm_pkg::OP_SEND: cur_rd_node = in_dest_node[swrm_pkg::NODE_W-1:0];
      swrm_pkg::OP_TICK: cur_rd_node = pend.target_nxt;
      default:           cur_rd_node = in_source_node;
    endcase
  end

  swrm_seq_mem #(.MAX_NODES(MAX_NODES)) u_exp_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_node (in_source_node),
    .wr      (exp_wr),
    .rd_data (exp_rd)
  );

  swrm_seq_mem #(.MAX_NODES(MAX_NODES)) u_cur_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_node (cur_rd_node),
    .wr      (cur_wr),
    .rd_data (cur_rd)
  );

  swrm_exec u_exec (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (x_fire),
    .item   (x_item_r),
    .cfg    (cfg_r),
    .exp_rd (exp_rd),
    .cur_rd (cur_rd),
    .res0   (res0),
    .res1   (res1),
    .res_n  (res_n),
    .exp_wr (exp_wr),
    .cur_wr (cur_wr),
    .pend   (pend)
  );

  swrm_out_fifo u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (x_fire),
    .push_n  (res_n),
    .res0    (res0),
    .res1    (res1),
    .room    (room),
    .out_vld (out_valid),
    .pop     (!out_stall),
    .head    (head)
  );

  assign out_action      = head.action;
  assign out_frame_kind  = head.frame_kind;
  assign out_target_node = head.target_node;
  assign out_origin_node = head.origin_node;
  assign out_seq_out     = head.seq_out;
  assign out_last        = head.last;

  a_result_reaches_port: assert property (@(posedge clk) disable iff (!rst_n)
    (x_fire && res_n != 2'd0) |=> out_valid)
    else $error("fired request with results left the output empty");

  a_success_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (x_fire && res_n == 2'd1 && res0.action == swrm_pkg::ACT_SUCCESS) |=> !pend.flag)
    else $error("pending message survived a matching confirm");

  a_accept_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (x_fire && res_n == 2'd1 && res0.action == swrm_pkg::ACT_ACCEPTED) |=> pend.flag)
    else $error("accepted send left no pending message");

  a_pair_is_confirm_then_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    (x_fire && res_n == 2'd2) |->
      (res0.action == swrm_pkg::ACT_CONFIRM && !res0.last &&
       res1.action == swrm_pkg::ACT_DELIVER && res1.last))
    else $error("two-result request is not confirm followed by delivery");

  a_write_only_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_wr.en || cur_wr.en) |-> x_fire)
    else $error("sequence memory written without a firing request");

endmodule

@@ design/swrm_seq_mem.sv @@
module swrm_seq_mem #(
  parameter int MAX_NODES = swrm_pkg::MAX_NODES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [swrm_pkg::NODE_W-1:0]  rd_node,
  input  swrm_pkg::mem_wr_t            wr,
  output logic [swrm_pkg::SEQ_W-1:0]   rd_data
);

  localparam int IW = $clog2(MAX_NODES);

  logic [IW-1:0]               idx_lut [swrm_pkg::NODE_SPACE];
  logic [swrm_pkg::SEQ_W-1:0]  mem [MAX_NODES];
  logic [MAX_NODES-1:0]        vld_r;
  logic [swrm_pkg::SEQ_W-1:0]  rd_data_r;
  logic [IW-1:0]               ra;
  logic [IW-1:0]               wa;
  logic                        byp;

  // node number to entry, modulo the node count
  for (genvar g = 0; g < swrm_pkg::NODE_SPACE; g++) begin : g_lut
    assign idx_lut[g] = IW'(g % MAX_NODES);
  end

  assign ra  = idx_lut[rd_node];
  assign wa  = idx_lut[wr.node];
  assign byp = wr.en && (wa == ra);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wa] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wa] <= 1'b1;
    end
  end

  // take the write of this edge in place of the stale entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (byp) begin
        rd_data_r <= wr.data;
      end else if (vld_r[ra]) begin
        rd_data_r <= mem[ra];
      end else begin
        rd_data_r <= '0;
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/swrm_exec.sv @@
module swrm_exec (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  swrm_pkg::item_t             item,
  input  swrm_pkg::cfg_t              cfg,
  input  logic [swrm_pkg::SEQ_W-1:0]  exp_rd,
  input  logic [swrm_pkg::SEQ_W-1:0]  cur_rd,
  output swrm_pkg::res_t              res0,
  output swrm_pkg::res_t              res1,
  output logic [1:0]                  res_n,
  output swrm_pkg::mem_wr_t           exp_wr,
  output swrm_pkg::mem_wr_t           cur_wr,
  output swrm_pkg::pend_t             pend
);

  logic                          pend_r, pend_nxt;
  logic [swrm_pkg::NODE_W-1:0]   ptgt_r, ptgt_nxt;
  logic [swrm_pkg::TIME_W-1:0]   nst_r, nst_nxt;
  logic [swrm_pkg::ATT_W-1:0]    att_r, att_nxt;

  logic                          dneg;
  logic [swrm_pkg::NODE_W-1:0]   dst;
  logic                          exp_we, cur_we;
  logic [swrm_pkg::NODE_W-1:0]   cur_node;

  assign dneg = item.dest_node[swrm_pkg::DEST_W-1];
  assign dst  = item.dest_node[swrm_pkg::NODE_W-1:0];

  always_comb begin
    res0     = '0;
    res1     = '0;
    res_n    = 2'd0;
    pend_nxt = pend_r;
    ptgt_nxt = ptgt_r;
    nst_nxt  = nst_r;
    att_nxt  = att_r;
    exp_we   = 1'b0;
    cur_we   = 1'b0;
    cur_node = item.source_node;
    res0.origin_node = cfg.own_id;
    res0.last        = 1'b1;
    case (swrm_pkg::op_t'(item.operation))
      swrm_pkg::OP_CHAT, swrm_pkg::OP_CONFIRM, swrm_pkg::OP_OTHER: begin
        if (dneg || dst != cfg.own_id) begin
          res0.action      = swrm_pkg::ACT_FORWARD;
          res0.frame_kind  = swrm_pkg::kind_t'(item.operation[swrm_pkg::KIND_W-1:0]);
          res0.target_node = dst;
          res0.origin_node = item.source_node;
          res0.seq_out     = item.seq_number;
          res_n            = 2'd1;
        end else if (swrm_pkg::op_t'(item.operation) == swrm_pkg::OP_CHAT) begin
          res0.action      = swrm_pkg::ACT_CONFIRM;
          res0.frame_kind  = swrm_pkg::KIND_CONFIRM;
          res0.target_node = item.source_node;
          res0.seq_out     = item.seq_number;
          if (item.seq_number >= exp_rd) begin
            res0.last        = 1'b0;
            res1.action      = swrm_pkg::ACT_DELIVER;
            res1.frame_kind  = swrm_pkg::KIND_CHAT;
            res1.target_node = item.source_node;
            res1.origin_node = item.source_node;
            res1.seq_out     = item.seq_number;
            res1.last        = 1'b1;
            res_n            = 2'd2;
            exp_we           = 1'b1;
          end else begin
            res_n = 2'd1;
          end
        end else if (swrm_pkg::op_t'(item.operation) == swrm_pkg::OP_CONFIRM &&
                     item.seq_number == cur_rd) begin
          res0.action      = swrm_pkg::ACT_SUCCESS;
          res0.frame_kind  = swrm_pkg::KIND_CONFIRM;
          res0.target_node = item.source_node;
          res0.origin_node = item.source_node;
          res0.seq_out     = item.seq_number;
          res_n            = 2'd1;
          cur_we           = 1'b1;
          pend_nxt         = 1'b0;
        end
      end
      swrm_pkg::OP_SEND: begin
        res0.frame_kind = swrm_pkg::KIND_CHAT;
        res_n           = 2'd1;
        if (dneg) begin
          res0.action = swrm_pkg::ACT_REFUSED;
        end else if (pend_r) begin
          res0.action      = swrm_pkg::ACT_BUSY;
          res0.target_node = ptgt_r;
        end else begin
          res0.action      = swrm_pkg::ACT_ACCEPTED;
          res0.target_node = dst;
          res0.seq_out     = cur_rd;
          pend_nxt         = 1'b1;
          nst_nxt          = item.now_ms;
          ptgt_nxt         = dst;
          att_nxt          = cfg.max_attempts;
        end
      end
      swrm_pkg::OP_TICK: begin
        cur_node = ptgt_r;
        if (!cfg.sleeping && pend_r && item.now_ms >= nst_r) begin
          res0.frame_kind  = swrm_pkg::KIND_CHAT;
          res0.target_node = ptgt_r;
          res0.seq_out     = cur_rd;
          res_n            = 2'd1;
          if (att_r == '0) begin
            res0.action = swrm_pkg::ACT_FAILED;
            cur_we      = 1'b1;
            pend_nxt    = 1'b0;
          end else begin
            res0.action = swrm_pkg::ACT_CHAT;
            att_nxt     = att_r - 1'b1;
            nst_nxt     = nst_r + swrm_pkg::TIME_W'(cfg.retry_timeout);
          end
        end
      end
      default: begin
        res_n = 2'd0;
      end
    endcase
  end

  // chat delivery and confirm both store the received number plus one;
  // a failure stores the abandoned number plus one
  assign exp_wr.en   = fire && exp_we;
  assign exp_wr.node = item.source_node;
  assign exp_wr.data = item.seq_number + 1'b1;
  assign cur_wr.en   = fire && cur_we;
  assign cur_wr.node = cur_node;
  assign cur_wr.data = cur_rd + 1'b1;

  assign pend.flag       = pend_r;
  assign pend.target_nxt = fire ? ptgt_nxt : ptgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      ptgt_r <= '0;
      nst_r  <= '0;
      att_r  <= '0;
    end else if (fire) begin
      pend_r <= pend_nxt;
      ptgt_r <= ptgt_nxt;
      nst_r  <= nst_nxt;
      att_r  <= att_nxt;
    end
  end

endmodule

@@ design/swrm_out_fifo.sv @@
module swrm_out_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic [1:0]      push_n,
  input  swrm_pkg::res_t  res0,
  input  swrm_pkg::res_t  res1,
  output logic            room,
  output logic            out_vld,
  input  logic            pop,
  output swrm_pkg::res_t  head
);

  localparam int DEPTH = swrm_pkg::OUTQ_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  swrm_pkg::res_t  buf_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [1:0]      n_in;
  logic            n_out;

  assign n_in  = push ? push_n : 2'd0;
  assign n_out = pop && out_vld;

  assign room    = cnt_r <= CW'(DEPTH - 2);
  assign out_vld = cnt_r != '0;
  assign head    = buf_r[rp_r];
  assign cnt_nxt = cnt_r + CW'(n_in) - CW'(n_out);

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      buf_r[wp_r] <= res0;
    end
    if (n_in == 2'd2) begin
      buf_r[wp_r + 1'b1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + PW'(n_in);
      rp_r  <= rp_r + PW'(n_out);
      cnt_r <= cnt_nxt;
    end
  end

endmodule
